@@ hdl/pssp_pkg.sv @@
// ----------------------------------------------------------------------------
// pssp_pkg
// Shared types and constants for the protobuf sample stream parser.
// ----------------------------------------------------------------------------
package pssp_pkg;

    // parse phase of the wire-format decoder
    typedef enum logic [2:0] {
        PH_KEY    = 3'd0,
        PH_VALUE  = 3'd1,
        PH_LEN    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_PACKED = 3'd4
    } t_phase;

    // what the current field carries
    typedef enum logic [1:0] {
        FK_OTHER    = 2'd0,
        FK_SAMPLE   = 2'd1,
        FK_CHANNELS = 2'd2
    } t_field;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    // field numbers
    localparam logic [31:0] FIELD_SAMPLES  = 32'd1;
    localparam logic [31:0] FIELD_CHANNELS = 32'd2;

    // result kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int ACC_W    = 64;
    localparam int REM_W    = 24;
    localparam int VALUE_W  = 31;
    localparam int VCOUNT_W = 4;

    // largest varint is ten bytes
    localparam logic [VCOUNT_W-1:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [VCOUNT_W-1:0] VARINT_LAST_SLOT = 4'd9;

    localparam logic [32:0] MAX_MESSAGE_BYTES = 33'd16777216;

    localparam logic [7:0] SAMPLE_SAT = 8'd255;

endpackage

@@ hdl/protobuf_sample_stream_parser.sv @@
// ----------------------------------------------------------------------------
// protobuf_sample_stream_parser
// Decodes a protobuf Signal message one byte per item, emits field 1 samples
// and an end-of-message summary with the channel count.
// ----------------------------------------------------------------------------
// stages: an item goes through the input register, then the result register;
//   end items always produce a summary item
// throughput: one item per cycle unless the output stalls; the per-byte varint update sets the pace
// reset: synchronous active-low i_rst_n clears both stages and the parse state
module protobuf_sample_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte[7:0], bytes_remaining[31:8]
    input  logic        s_axis_tlast,   // operation: end of message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[30:0], status[31]
    output logic        m_axis_tuser    // kind[0]
);
    import pssp_pkg::*;

    // input register
    logic             r_in_valid;
    logic             r_in_last;
    logic [7:0]       r_in_byte;
    logic [REM_W-1:0] r_in_rem;

    // parse state
    t_phase              r_phase,   n_phase;
    logic [ACC_W-1:0]    r_acc,     n_acc;
    logic [VCOUNT_W-1:0] r_vcount,  n_vcount;
    t_field              r_field,   n_field;
    logic [REM_W-1:0]    r_region,  n_region;
    logic [31:0]         r_chan,    n_chan;
    logic                r_error,   n_error;

    // result register
    logic               r_out_valid;
    logic               r_out_kind;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_status;

    logic               res_valid;
    logic               res_kind;
    logic [VALUE_W-1:0] res_value;
    logic               res_status;

    logic advance;

    // varint byte add, shared by all varint phases
    logic [6:0]          sh;
    logic [ACC_W-1:0]    acc_add;
    logic [VCOUNT_W-1:0] cnt_add;
    logic                above_add;
    logic                more;
    logic [7:0]          sample_add;
    logic [31:0]         key_field;
    logic [2:0]          key_wire;
    logic [REM_W-1:0]    region_dec;
    logic [31:0]         chan_rep;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign sh        = 7'(r_vcount) * 7'd7;
    assign acc_add   = (r_vcount <= VARINT_LAST_SLOT)
                     ? (r_acc | ({57'd0, r_in_byte[6:0]} << sh)) : r_acc;
    assign cnt_add   = r_vcount + 4'd1;
    assign above_add = |acc_add[ACC_W-1:8];
    assign more      = r_in_byte[7];
    assign sample_add = above_add ? SAMPLE_SAT : acc_add[7:0];
    assign key_field = acc_add[34:3];
    assign key_wire  = acc_add[2:0];
    assign region_dec = (r_region != '0) ? r_region - 1'b1 : r_region;
    assign chan_rep  = (r_chan == '0 || r_chan[31]) ? 32'd1 : r_chan;

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_vcount   = r_vcount;
        n_field    = r_field;
        n_region   = r_region;
        n_chan     = r_chan;
        n_error    = r_error;
        res_valid  = 1'b0;
        res_kind   = KIND_SAMPLE;
        res_value  = VALUE_W'(sample_add);
        res_status = 1'b0;

        if (r_in_last) begin
            res_valid  = 1'b1;
            res_kind   = KIND_SUMMARY;
            res_value  = chan_rep[VALUE_W-1:0];
            res_status = r_error || (r_phase != PH_KEY) || (r_vcount != '0);
            n_phase    = PH_KEY;
            n_acc      = '0;
            n_vcount   = '0;
            n_field    = FK_OTHER;
            n_region   = '0;
            n_chan     = '0;
            n_error    = 1'b0;
        end else if (r_error) begin
            // ignore bytes until the end item
        end else if ({9'd0, r_in_rem} >= MAX_MESSAGE_BYTES) begin
            n_error = 1'b1;
        end else begin
            case (r_phase)
                PH_SKIP: begin
                    n_region = region_dec;
                    if (region_dec == '0) begin
                        n_phase = PH_KEY;
                    end
                end
                PH_PACKED: begin
                    n_region = region_dec;
                    if (!more || cnt_add == VARINT_MAX_BYTES || region_dec == '0) begin
                        res_valid = 1'b1;
                        n_acc     = '0;
                        n_vcount  = '0;
                        if (region_dec == '0) begin
                            n_phase = PH_KEY;
                        end else if (more) begin
                            // overlong varint: drop the rest of the region
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_acc    = acc_add;
                        n_vcount = cnt_add;
                    end
                end
                default: begin
                    if (more) begin
                        n_acc    = acc_add;
                        n_vcount = cnt_add;
                        if (cnt_add == VARINT_MAX_BYTES || r_in_rem == '0) begin
                            n_error = 1'b1;
                        end
                    end else begin
                        n_acc    = '0;
                        n_vcount = '0;
                        n_phase  = PH_KEY;
                        case (r_phase)
                            PH_KEY: begin
                                n_field = FK_OTHER;
                                case (key_wire)
                                    WT_VARINT: begin
                                        if (key_field == FIELD_SAMPLES) begin
                                            n_field = FK_SAMPLE;
                                        end else if (key_field == FIELD_CHANNELS) begin
                                            n_field = FK_CHANNELS;
                                        end
                                        n_phase = PH_VALUE;
                                        if (r_in_rem == '0) n_error = 1'b1;
                                    end
                                    WT_LEN: begin
                                        if (key_field == FIELD_SAMPLES) begin
                                            n_field = FK_SAMPLE;
                                        end
                                        n_phase = PH_LEN;
                                        if (r_in_rem == '0) n_error = 1'b1;
                                    end
                                    WT_I64: begin
                                        if (r_in_rem < REM_W'(8)) begin
                                            n_error = 1'b1;
                                        end else begin
                                            n_region = REM_W'(8);
                                            n_phase  = PH_SKIP;
                                        end
                                    end
                                    WT_I32: begin
                                        if (r_in_rem < REM_W'(4)) begin
                                            n_error = 1'b1;
                                        end else begin
                                            n_region = REM_W'(4);
                                            n_phase  = PH_SKIP;
                                        end
                                    end
                                    default: begin
                                        n_error = 1'b1;
                                    end
                                endcase
                            end
                            PH_VALUE: begin
                                if (r_field == FK_SAMPLE) begin
                                    res_valid = 1'b1;
                                end else if (r_field == FK_CHANNELS) begin
                                    n_chan = acc_add[31:0];
                                end
                            end
                            default: begin
                                // length of a length-delimited field
                                if (acc_add > {40'd0, r_in_rem}) begin
                                    n_error = 1'b1;
                                end else if (acc_add != '0) begin
                                    n_region = acc_add[REM_W-1:0];
                                    n_phase  = (r_field == FK_SAMPLE) ? PH_PACKED : PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_KEY;
            r_acc       <= '0;
            r_vcount    <= '0;
            r_field     <= FK_OTHER;
            r_region    <= '0;
            r_chan      <= '0;
            r_error     <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_vcount    <= n_vcount;
                r_field     <= n_field;
                r_region    <= n_region;
                r_chan      <= n_chan;
                r_error     <= n_error;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_last <= s_axis_tlast;
            r_in_byte <= s_axis_tdata[7:0];
            r_in_rem  <= s_axis_tdata[31:8];
        end
        if (advance && res_valid) begin
            r_out_kind   <= res_kind;
            r_out_value  <= res_value;
            r_out_status <= res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_value};
    assign m_axis_tuser  = r_out_kind;

endmodule

@@ hdl/pssp_checker.sv @@
// ----------------------------------------------------------------------------
// pssp_checker
// Port-level checks for the protobuf sample stream parser.
// ----------------------------------------------------------------------------
module pssp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import pssp_pkg::*;

    // both stages empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // samples are saturated and never flagged malformed
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SAMPLE |->
            m_axis_tdata[30:8] == '0 && !m_axis_tdata[31])
        else $error("sample out of range or with error status");

    // a summary always reports at least one channel
    a_summary_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |-> m_axis_tdata[30:0] != '0)
        else $error("summary with zero channel count");

    // an end item passes the input register, then the result register, and comes out as a summary if nothing stalls
    a_end_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && m_axis_tready
            ##1 m_axis_tready |=> m_axis_tvalid && m_axis_tuser == KIND_SUMMARY)
        else $error("end item did not produce a summary");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind protobuf_sample_stream_parser pssp_checker u_pssp_checker (.*);

@@ verif/protobuf_sample_stream_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_sample_stream_parser_test
// Drives wire-format messages through the parser one byte per item and
// checks every sample and end-of-message summary against a built-in model.
// Directed messages come first, then random messages, most of them well
// formed with random content, some cut short, corrupted or pure noise.
// ----------------------------------------------------------------------------
module protobuf_sample_stream_parser_test;
    import pssp_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int RANDOM_ITEMS    = 1130;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  value;
        logic                status;
    } result_t;

    typedef struct packed {
        logic              is_end;
        logic [7:0]        data;
        logic [REM_W-1:0]  rem;
    } stim_item_t;

    // decoder state mirror and the results it still owes
    class pssp_scoreboard;
        t_phase              phase;
        logic [ACC_W-1:0]    acc;
        logic [VCOUNT_W-1:0] nbytes;
        logic                above;
        t_field              fkind;
        logic [2:0]          wkind;
        logic [REM_W-1:0]    region;
        logic [31:0]         chan_word;
        logic                err;
        result_t             owed_q[$];
        int                  n_fail;

        function new();
            n_fail = 0;
            clear_all();
        endfunction

        function void clear_varint();
            acc    = '0;
            nbytes = '0;
            above  = 1'b0;
        endfunction

        function void clear_all();
            phase     = PH_KEY;
            clear_varint();
            fkind     = FK_OTHER;
            wkind     = '0;
            region    = '0;
            chan_word = '0;
            err       = 1'b0;
        endfunction

        function logic add_byte(logic [7:0] b);
            int sh;
            sh = 7 * nbytes;
            if (sh < 64) acc |= {57'd0, b[6:0]} << sh;
            nbytes++;
            above = (acc > 64'd255);
            return b[7];
        endfunction

        function void owe_sample();
            result_t r;
            r.kind   = KIND_SAMPLE;
            r.value  = above ? 31'(SAMPLE_SAT) : 31'(acc[7:0]);
            r.status = 1'b0;
            owed_q   = {owed_q, r};
        endfunction

        function void key_done(logic [REM_W-1:0] rem);
            logic [31:0] fnum;
            logic [2:0]  wtype;
            int unsigned need;
            fnum  = acc[34:3];
            wtype = acc[2:0];
            clear_varint();
            wkind = wtype;
            fkind = FK_OTHER;
            phase = PH_KEY;
            if (wtype == WT_VARINT) begin
                if (fnum == FIELD_SAMPLES) fkind = FK_SAMPLE;
                else if (fnum == FIELD_CHANNELS) fkind = FK_CHANNELS;
                phase = PH_VALUE;
                if (rem == 0) err = 1'b1;
            end else if (wtype == WT_LEN) begin
                if (fnum == FIELD_SAMPLES) fkind = FK_SAMPLE;
                phase = PH_LEN;
                if (rem == 0) err = 1'b1;
            end else if (wtype == WT_I64 || wtype == WT_I32) begin
                need = (wtype == WT_I64) ? 8 : 4;
                if (rem < need) begin
                    err = 1'b1;
                end else begin
                    region = REM_W'(need);
                    phase  = PH_SKIP;
                end
            end else begin
                err = 1'b1;
            end
        endfunction

        function void note_item(logic is_end, logic [7:0] b, logic [REM_W-1:0] rem);
            result_t     r;
            logic [31:0] ch;
            logic        more;
            logic [63:0] len;
            if (is_end) begin
                ch = chan_word;
                if (ch == 0 || ch[31]) ch = 32'd1;
                r.kind   = KIND_SUMMARY;
                r.value  = ch[30:0];
                r.status = err || phase != PH_KEY || nbytes != 0;
                owed_q   = {owed_q, r};
                clear_all();
                return;
            end
            if (err) return;
            if ({9'd0, rem} >= MAX_MESSAGE_BYTES) begin
                err = 1'b1;
                return;
            end
            case (phase)
                PH_SKIP: begin
                    if (region > 0) region--;
                    if (region == 0) phase = PH_KEY;
                end
                PH_PACKED: begin
                    more = add_byte(b);
                    if (region > 0) region--;
                    if (!more || nbytes == VARINT_MAX_BYTES || region == 0) begin
                        owe_sample();
                        clear_varint();
                        // an overlong varint skips what is left of the region
                        if (region == 0) phase = PH_KEY;
                        else if (more) phase = PH_SKIP;
                    end
                end
                default: begin
                    more = add_byte(b);
                    if (more) begin
                        if (nbytes == VARINT_MAX_BYTES || rem == 0) err = 1'b1;
                    end else if (phase == PH_KEY) begin
                        key_done(rem);
                    end else if (phase == PH_VALUE) begin
                        if (fkind == FK_SAMPLE) owe_sample();
                        else if (fkind == FK_CHANNELS) chan_word = acc[31:0];
                        clear_varint();
                        phase = PH_KEY;
                    end else begin
                        len = acc;
                        clear_varint();
                        phase = PH_KEY;
                        if (len > {40'd0, rem}) begin
                            err = 1'b1;
                        end else if (len != 0) begin
                            region = len[REM_W-1:0];
                            phase  = (fkind == FK_SAMPLE) ? PH_PACKED : PH_SKIP;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [VALUE_W-1:0] value, logic status);
            result_t e;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%0d status=%0d",
                         $time, kind, value, status);
                n_fail++;
                return;
            end
            e = owed_q.pop_front();
            if (kind !== e.kind || value !== e.value || status !== e.status) begin
                $display("%0t: mismatch expected kind=%0d value=%0d status=%0d,",
                         $time, e.kind, e.value, e.status,
                         " got kind=%0d value=%0d status=%0d", kind, value, status);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // data_byte[7:0], bytes_remaining[31:8]
    logic        s_axis_tlast  = 1'b0; // operation: end of message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // value[30:0], status[31]
    logic        m_axis_tuser;         // kind[0]

    pssp_scoreboard sb;
    stim_item_t     stim_q[$];
    logic [7:0]     msg_q[$];
    int             n_accepted  = 0;
    int             idle_cycles = 0;

    protobuf_sample_stream_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // message construction
    // ------------------------------------------------------------------
    function automatic void put_varint(logic [63:0] v);
        logic [63:0] rest;
        do begin
            rest  = v >> 7;
            msg_q = {msg_q, {rest != 0, v[6:0]}};
            v     = rest;
        end while (v != 0);
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 255));
            1: return 64'($urandom_range(256, 70000));
            2: return {$urandom, $urandom};
            3: return 64'd0;
            4: return 64'd255;
            default: return 64'd256;
        endcase
    endfunction

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 3))
            0: return $urandom_range(3, 15);
            1: return $urandom_range(16, 5000);
            2: return $urandom;
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    function automatic logic [63:0] make_key(logic [31:0] fnum, logic [2:0] wtype);
        logic [28:0] hi;
        // junk above the 32-bit field number must not matter
        hi = ($urandom_range(0, 7) == 0) ? 29'($urandom) : 29'd0;
        return {hi, fnum, wtype};
    endfunction

    function automatic void put_random_bytes(int n);
        repeat (n) msg_q = {msg_q, 8'($urandom)};
    endfunction

    function automatic void put_packed_samples();
        logic [7:0] saved[$];
        logic [7:0] body[$];
        saved = msg_q;
        msg_q.delete();
        repeat ($urandom_range(0, 5)) put_varint(pick_value());
        case ($urandom_range(0, 9))
            0: begin
                // last varint cut off by the end of the region
                put_varint(64'($urandom_range(128, 1 << 20)));
                void'(msg_q.pop_back());
            end
            1: begin
                repeat (10) msg_q = {msg_q, 8'h80 | 8'($urandom)};
                put_random_bytes($urandom_range(0, 3));
            end
            default: ;
        endcase
        body  = msg_q;
        msg_q = saved;
        put_varint(make_key(FIELD_SAMPLES, WT_LEN));
        put_varint(64'(body.size()));
        msg_q = {msg_q, body};
    endfunction

    function automatic void put_field();
        int           r;
        int           n;
        logic [2:0]   bad_wires[4];
        bad_wires = '{3'd3, 3'd4, 3'd6, 3'd7};
        r = $urandom_range(0, 99);
        if (r < 30) begin
            put_varint(make_key(FIELD_SAMPLES, WT_VARINT));
            put_varint(pick_value());
        end else if (r < 45) begin
            put_packed_samples();
        end else if (r < 55) begin
            put_varint(make_key(FIELD_CHANNELS, WT_VARINT));
            case ($urandom_range(0, 3))
                0: put_varint(64'($urandom));
                1: put_varint({32'hFFFF_FFFF, 1'b1, 31'($urandom)});
                2: put_varint(64'd0);
                default: put_varint(64'($urandom_range(1, 16)));
            endcase
        end else if (r < 65) begin
            put_varint(make_key(pick_field(), WT_VARINT));
            put_varint(pick_value());
        end else if (r < 73) begin
            put_varint(make_key(pick_field(), WT_I64));
            put_random_bytes(8);
        end else if (r < 81) begin
            put_varint(make_key(pick_field(), WT_I32));
            put_random_bytes(4);
        end else if (r < 92) begin
            n = $urandom_range(0, 8);
            put_varint(make_key(pick_field(), WT_LEN));
            put_varint(64'(n));
            put_random_bytes(n);
        end else if (r < 96) begin
            put_varint(make_key(pick_field(), bad_wires[$urandom_range(0, 3)]));
            put_random_bytes(2);
        end else begin
            // more than ten varint bytes, in a value or in the key itself
            if ($urandom_range(0, 1)) put_varint(make_key(FIELD_SAMPLES, WT_VARINT));
            repeat ($urandom_range(10, 12)) msg_q = {msg_q, 8'h80 | 8'($urandom)};
            put_random_bytes($urandom_range(0, 2));
        end
    endfunction

    function automatic void queue_message(logic [REM_W-1:0] base, bit wild_rem);
        stim_item_t it;
        int         n;
        n = msg_q.size();
        for (int i = 0; i < n; i++) begin
            it.is_end = 1'b0;
            it.data   = msg_q[i];
            it.rem    = wild_rem ? REM_W'($urandom) : base + REM_W'(n - 1 - i);
            stim_q    = {stim_q, it};
        end
        it.is_end = 1'b1;
        it.data   = 8'($urandom);
        it.rem    = REM_W'($urandom);
        stim_q    = {stim_q, it};
        msg_q.delete();
    endfunction

    function automatic void build_stimulus();
        int n_directed;
        int c;
        int n;
        // samples 0, 300 saturated, packed 5 and 256 saturated, channel count 3
        msg_q = '{8'h08, 8'h00, 8'h08, 8'hAC, 8'h02, 8'h10, 8'h03,
                  8'h0A, 8'h03, 8'h05, 8'h80, 8'h02};
        queue_message('0, 1'b0);
        // empty message
        queue_message('0, 1'b0);
        // bad wire type at the largest byte count, later byte ignored
        msg_q = '{8'h0B, 8'hFF};
        queue_message(24'hFF_FFFE, 1'b0);
        // negative channel count, then end in the middle of a field
        msg_q = '{8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h08};
        queue_message(REM_W'(1), 1'b0);
        n_directed = stim_q.size();

        while (stim_q.size() - n_directed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 5) begin
                put_random_bytes($urandom_range(1, 12));
                queue_message('0, 1'b1);
            end else begin
                repeat ($urandom_range(0, 6)) put_field();
                c = $urandom_range(0, 99);
                if (c < 8 && msg_q.size() > 0) begin
                    n = $urandom_range(0, msg_q.size() - 1);
                    while (msg_q.size() > n) void'(msg_q.pop_back());
                end else if (c < 14 && msg_q.size() > 0) begin
                    msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
                end else if (c < 18) begin
                    put_random_bytes($urandom_range(1, 4));
                end
                queue_message(($urandom_range(0, 4) == 0) ?
                              REM_W'($urandom_range(0, 24'hFF_F000)) : '0,
                              $urandom_range(0, 29) == 0);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    task automatic send_all();
        int idx;
        int burst;
        int gap;
        idx = 0;
        while (idx < stim_q.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < stim_q.size()) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b1;
                s_axis_tlast  <= stim_q[idx].is_end;
                s_axis_tdata  <= {stim_q[idx].rem, stim_q[idx].data};
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int ready_mode;
        int seg_left;
        bit hold_done;
        ready_mode = 0;
        seg_left   = 0;
        hold_done  = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_accepted >= HOLD_OFF_AFTER) begin
                // long hold-off so the block backs up and stalls its input
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_done = 1;
            end else begin
                if (seg_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    seg_left   = $urandom_range(5, 60);
                end
                seg_left--;
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tlast, s_axis_tdata[7:0], s_axis_tdata[31:8]);
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[31]);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        sb = new();
        build_stimulus();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_all();
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pssp_pkg.sv
hdl/protobuf_sample_stream_parser.sv
hdl/pssp_checker.sv
verif/protobuf_sample_stream_parser_test.sv
